>>> hw/rtl/sff_pkg.sv
package sff_pkg;

	localparam int MAX_HALF_ORDER = 64;
	localparam int NUM_CHANNELS   = 2;
	localparam int CHAN_TAPS      = 2 * MAX_HALF_ORDER + 1;
	localparam int MEM_DEPTH      = NUM_CHANNELS * CHAN_TAPS;

	localparam int SMP_W  = 16;
	localparam int HO_W   = 7;
	localparam int TAPI_W = 8;
	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam int IDX_W  = $clog2(CHAN_TAPS);
	localparam int TAP_W  = $clog2(CHAN_TAPS + 1);
	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int PROD_W = 2 * SMP_W;
	localparam int ACC_W  = PROD_W + $clog2(CHAN_TAPS);
	localparam int FRAC_W = 15;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_FILTER = 1'b1;

	typedef struct packed {
		logic start;
		logic coef_wr;
		logic issue;
		logic do_abs;
		logic do_round;
		logic out_load;
	} sff_cmd_t;

	typedef struct packed {
		logic item_sample;
		logic item_load;
		logic last_tap;
		logic pipe_busy;
		logic out_free;
	} sff_status_t;

	function automatic logic [ADDR_W-1:0] chan_base(input logic [CH_W-1:0] ch);
		return ADDR_W'(ch) * ADDR_W'(CHAN_TAPS);
	endfunction

endpackage

>>> hw/rtl/stereo_fir_filter.sv
// Two-channel direct-form FIR filter, 2M+1 taps per channel (M = half_order, 1..64,
// reset 1; 0 acts as 1, above 64 as 64). A request with cmd = 0 loads one Q1.15
// coefficient at tap_index into the chosen channel's store and returns nothing;
// indexes beyond 128 are dropped. Load every tap in use before filtering with it.
// A request with cmd = 1 pushes sample_in into that channel's history (zero before
// the first sample) and returns one sample_out, the exact Q.15 dot product rounded
// half away from zero and saturated to 16 bits, tagged with out_channel.
// A filter request stalls the input from acceptance until its result is handed off:
// one shared multiply-accumulate walks the taps, one per cycle, reading coefficient
// and history memories that each give one word per cycle; then the MAC pipeline
// drains and the drain check, magnitude, rounding and hand-off to the output register
// follow, the hand-off waiting while that register still holds a stalled result.
// A finished result sits in the output register, so the next request is taken
// while it waits. half_order may only be written while the block is idle.
module stereo_fir_filter
	import sff_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_wr_en,
	input  logic [HO_W-1:0]         cfg_wr_data,
	// request channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    cmd,
	input  logic                    channel,
	input  logic [TAPI_W-1:0]       tap_index,
	input  logic signed [SMP_W-1:0] coef_value,
	input  logic signed [SMP_W-1:0] sample_in,
	// result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SMP_W-1:0] sample_out,
	output logic                    out_channel
);

	sff_cmd_t    ctl;
	sff_status_t stat;

	// sequencer: idle / tap walk / pipeline drain / magnitude / round / hand-off
	sff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (ctl),
		.in_stall (in_stall)
	);

	// memories, circular history pointers, MAC pipeline, rounding, output register
	sff_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.channel     (channel),
		.tap_index   (tap_index),
		.coef_value  (coef_value),
		.sample_in   (sample_in),
		.ctl         (ctl),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_out  (sample_out),
		.out_channel (out_channel)
	);

endmodule

>>> hw/rtl/sff_ctrl.sv
module sff_ctrl
	import sff_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  sff_status_t stat,
	output sff_cmd_t    cmd,
	output logic        in_stall
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_ABS   = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.coef_wr = in_valid && stat.item_load;
				cmd.start   = in_valid && stat.item_sample;
				if (cmd.start) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (stat.last_tap) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_nxt = ST_ABS;
				end
			end
			ST_ABS: begin
				cmd.do_abs = 1'b1;
				state_nxt  = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.do_round = 1'b1;
				state_nxt    = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> hw/rtl/sff_datapath.sv
module sff_datapath
	import sff_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [HO_W-1:0]         cfg_wr_data,
	input  logic                    cmd,
	input  logic                    channel,
	input  logic [TAPI_W-1:0]       tap_index,
	input  logic signed [SMP_W-1:0] coef_value,
	input  logic signed [SMP_W-1:0] sample_in,
	input  sff_cmd_t                ctl,
	output sff_status_t             stat,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SMP_W-1:0] sample_out,
	output logic                    out_channel
);

	logic signed [SMP_W-1:0] coef_mem [MEM_DEPTH];
	logic signed [SMP_W-1:0] hist_mem [MEM_DEPTH];

	logic [HO_W-1:0]  half_order_q;
	logic [IDX_W-1:0] head_q [NUM_CHANNELS];
	logic [TAP_W-1:0] fill_q [NUM_CHANNELS];

	logic [CH_W-1:0]  ch_q;
	logic [TAP_W-1:0] taps_q;
	logic [TAP_W-1:0] tap_cnt_q;
	logic [TAP_W-1:0] cur_fill_q;
	logic [IDX_W-1:0] rd_idx_q;

	logic                     issue_s1;
	logic                     hist_ok_s1;
	logic signed [SMP_W-1:0]  coef_rd_s1;
	logic signed [SMP_W-1:0]  hist_rd_s1;
	logic                     prod_v_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0]        mag_q;
	logic                    neg_q;
	logic [SMP_W-1:0]        res_q;
	logic                    out_valid_q;
	logic                    out_ch_q;

	logic [CH_W-1:0]   ch_in;
	logic              ch_ok;
	logic [TAP_W-1:0]  m_clamp;
	logic [TAP_W-1:0]  taps_nxt;
	logic [IDX_W-1:0]  head_nxt;
	logic [TAP_W-1:0]  fill_nxt;
	logic [ADDR_W-1:0] wr_addr_coef;
	logic [ADDR_W-1:0] wr_addr_hist;
	logic [ADDR_W-1:0] rd_addr_coef;
	logic [ADDR_W-1:0] rd_addr_hist;
	logic [ACC_W:0]    rnd;
	logic [ACC_W-FRAC_W:0] q;
	logic [SMP_W-1:0]  res_nxt;

	assign ch_in = CH_W'(channel);
	assign ch_ok = (32'(channel) < NUM_CHANNELS);

	// half order 0 acts as 1, anything above the maximum acts as the maximum
	always_comb begin
		if (half_order_q == '0) begin
			m_clamp = TAP_W'(1);
		end else if (32'(half_order_q) > MAX_HALF_ORDER) begin
			m_clamp = TAP_W'(MAX_HALF_ORDER);
		end else begin
			m_clamp = TAP_W'(half_order_q);
		end
		taps_nxt = (m_clamp << 1) + 1'b1;
	end

	assign head_nxt = (head_q[ch_in] == IDX_W'(CHAN_TAPS - 1)) ? '0 : head_q[ch_in] + 1'b1;
	assign fill_nxt = (fill_q[ch_in] == TAP_W'(CHAN_TAPS)) ? fill_q[ch_in]
	                                                         : fill_q[ch_in] + 1'b1;

	assign wr_addr_coef = chan_base(ch_in) + ADDR_W'(tap_index);
	assign wr_addr_hist = chan_base(ch_in) + ADDR_W'(head_nxt);
	assign rd_addr_coef = chan_base(ch_q) + ADDR_W'(tap_cnt_q);
	assign rd_addr_hist = chan_base(ch_q) + ADDR_W'(rd_idx_q);

	assign stat.item_sample = (cmd == CMD_FILTER) && ch_ok;
	assign stat.item_load   = (cmd == CMD_LOAD) && ch_ok && (32'(tap_index) < CHAN_TAPS);
	assign stat.last_tap    = (tap_cnt_q + 1'b1 == taps_q);
	assign stat.pipe_busy   = issue_s1 || prod_v_s2;
	assign stat.out_free    = !out_valid_q || !out_stall;

	// memories
	always_ff @(posedge clk) begin
		if (ctl.coef_wr) begin
			coef_mem[wr_addr_coef] <= coef_value;
		end
		if (ctl.start) begin
			hist_mem[wr_addr_hist] <= sample_in;
		end
		if (ctl.issue) begin
			coef_rd_s1 <= coef_mem[rd_addr_coef];
			hist_rd_s1 <= hist_mem[rd_addr_hist];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_order_q <= HO_W'(1);
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				head_q[i] <= IDX_W'(CHAN_TAPS - 1);
				fill_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				half_order_q <= cfg_wr_data;
			end
			if (ctl.start) begin
				head_q[ch_in] <= head_nxt;
				fill_q[ch_in] <= fill_nxt;
			end
		end
	end

	// per-item context, tap walk
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			ch_q       <= ch_in;
			taps_q     <= taps_nxt;
			cur_fill_q <= fill_nxt;
			tap_cnt_q  <= '0;
			rd_idx_q   <= head_nxt;
		end else if (ctl.issue) begin
			tap_cnt_q <= tap_cnt_q + 1'b1;
			rd_idx_q  <= (rd_idx_q == '0) ? IDX_W'(CHAN_TAPS - 1) : rd_idx_q - 1'b1;
		end
		if (ctl.issue) begin
			hist_ok_s1 <= (tap_cnt_q < cur_fill_q);
		end
		prod_s2 <= coef_rd_s1 * (hist_ok_s1 ? hist_rd_s1 : SMP_W'(0));
		if (ctl.start) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (ctl.do_abs) begin
			neg_q <= acc_q[ACC_W-1];
			mag_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		end
		if (ctl.do_round) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1  <= 1'b0;
			prod_v_s2 <= 1'b0;
		end else begin
			issue_s1  <= ctl.issue;
			prod_v_s2 <= issue_s1;
		end
	end

	// round half away from zero, saturate
	always_comb begin
		rnd = (ACC_W + 1)'(mag_q) + (ACC_W + 1)'(1 << (FRAC_W - 1));
		q   = rnd[ACC_W:FRAC_W];
		if (neg_q) begin
			res_nxt = (q > (ACC_W - FRAC_W + 1)'(32768)) ? 16'h8000 : SMP_W'(-q[SMP_W-1:0]);
		end else begin
			res_nxt = (q > (ACC_W - FRAC_W + 1)'(32767)) ? 16'h7fff : q[SMP_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			sample_out <= res_q;
			out_ch_q   <= ch_q[0];
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_ch_q;

endmodule

>>> hw/rtl/sff_checker.sv
module sff_checker
	import sff_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    cmd,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [SMP_W-1:0] sample_out,
	input logic                    out_channel
);

	logic smp_acc;
	logic load_acc;

	assign smp_acc  = in_valid && !in_stall && (cmd == CMD_FILTER);
	assign load_acc = in_valid && !in_stall && (cmd == CMD_LOAD);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(out_channel))
		else $error("stalled result changed");

	a_smp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc |=> in_stall)
		else $error("input free right after a filter request");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> !in_stall)
		else $error("load request blocked the input");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result appeared too soon after a filter request");

endmodule

bind stereo_fir_filter sff_checker u_sff_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.cmd         (cmd),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.sample_out  (sample_out),
	.out_channel (out_channel)
);

>>> bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sff_pkg::*;

	// run sizing
	localparam int ITEM_TARGET   = 1650;      // in-range loads + filter requests
	localparam int CYCLE_LIMIT   = 1_000_000; // cycle budget for the whole run
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 2 * MAX_HALF_ORDER + 8 + SETTLE_CYCLES;

	typedef struct packed {
		logic signed [SMP_W-1:0] smp;
		logic                    ch;
	} fir_result_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_t;

	// Scoreboard: own copy of both channels' coefficient and history stores
	// plus half_order; each filter request produces one expected output.
	class fir_scoreboard;
		logic signed [SMP_W-1:0] coef [NUM_CHANNELS][CHAN_TAPS];
		logic signed [SMP_W-1:0] hist [NUM_CHANNELS][CHAN_TAPS];
		logic [HO_W-1:0]         order_cfg;
		fir_result_t             filtered_due[$];
		int                      errors;
		int                      checked;

		function new();
			foreach (coef[c, k]) begin
				coef[c][k] = '0;
				hist[c][k] = '0;
			end
			order_cfg = 1;
			errors    = 0;
			checked   = 0;
		endfunction

		function void set_half_order(logic [HO_W-1:0] v);
			order_cfg = v;
		endfunction

		// 0 behaves as 1, anything past the maximum is clamped
		function int active_taps();
			int m;
			m = order_cfg;
			if (m < 1)
				m = 1;
			if (m > MAX_HALF_ORDER)
				m = MAX_HALF_ORDER;
			return 2 * m + 1;
		endfunction

		function int pending();
			return filtered_due.size();
		endfunction

		// exact Q.15 dot product, rounded half away from zero, saturated
		function logic signed [SMP_W-1:0] fir_output(logic ch);
			longint acc;
			longint mag;
			longint q;
			acc = 0;
			for (int k = 0; k < active_taps(); k++)
				acc += longint'(coef[ch][k]) * longint'(hist[ch][k]);
			mag = (acc < 0) ? -acc : acc;
			q = (mag + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
			if (acc < 0)
				q = -q;
			if (q > 32767)
				q = 32767;
			if (q < -32768)
				q = -32768;
			return q[SMP_W-1:0];
		endfunction

		function void note_request(logic c, logic ch, logic [TAPI_W-1:0] tap,
				logic signed [SMP_W-1:0] cf, logic signed [SMP_W-1:0] smp);
			fir_result_t r;
			if (c == CMD_LOAD) begin
				if (tap < CHAN_TAPS)
					coef[ch][tap] = cf;
				return;
			end
			for (int k = CHAN_TAPS - 1; k > 0; k--)
				hist[ch][k] = hist[ch][k-1];
			hist[ch][0] = smp;
			r.smp = fir_output(ch);
			r.ch  = ch;
			filtered_due.push_back(r);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("[%0t] %s", $time, msg);
		endfunction

		function void check_result(logic signed [SMP_W-1:0] smp, logic ch);
			fir_result_t e;
			if (filtered_due.size() == 0) begin
				flag($sformatf("unexpected output: sample_out %0d out_channel %0d", smp, ch));
				return;
			end
			e = filtered_due.pop_front();
			checked++;
			if (smp !== e.smp || ch !== e.ch)
				flag($sformatf("mismatch: sample_out exp %0d got %0d, out_channel exp %0d got %0d",
					e.smp, smp, e.ch, ch));
		endfunction
	endclass

	// clock, reset, DUT-facing signals (all driven ones known from time 0)
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                    cfg_wr_en   = 1'b0;
	logic [HO_W-1:0]         cfg_wr_data = '0;
	logic                    in_valid    = 1'b0;
	logic                    in_stall;
	logic                    cmd         = CMD_LOAD;
	logic                    channel     = 1'b0;
	logic [TAPI_W-1:0]       tap_index   = '0;
	logic signed [SMP_W-1:0] coef_value  = '0;
	logic signed [SMP_W-1:0] sample_in   = '0;
	logic                    out_valid;
	logic                    out_stall   = 1'b0;
	logic signed [SMP_W-1:0] sample_out;
	logic                    out_channel;

	always #4 clk = ~clk;

	stereo_fir_filter uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.channel     (channel),
		.tap_index   (tap_index),
		.coef_value  (coef_value),
		.sample_in   (sample_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_out  (sample_out),
		.out_channel (out_channel)
	);

	fir_scoreboard sb;

	// stimulus-side bookkeeping
	bit coef_loaded [NUM_CHANNELS][CHAN_TAPS]; // never filter over an unloaded tap
	bit gentle_coefs = 1'b0;                   // small coefficients -> fewer saturations
	int burst_left   = 0;
	int n_filter     = 0;
	int n_load       = 0;
	int n_stray      = 0;
	int n_settings   = 0;

	// Result side: check on accept, then pick the next stall value.
	// Stall behavior switches between four modes at random intervals.
	int          cycles     = 0;
	int          stall_hold = 0;
	stall_mode_t stall_mode = STALL_NONE;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outputs still due", cycles, sb.pending());
			$display("** stereo_fir_filter: FAILED **");
			$finish;
		end
		if (arst_n && out_valid && !out_stall)
			sb.check_result(sample_out, out_channel);
		if (stall_hold == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_hold = $urandom_range(40, 300);
		end else begin
			stall_hold--;
		end
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
			default:      out_stall <= ((cycles % 32) < 20);
		endcase
	end

	function automatic logic signed [SMP_W-1:0] rand_coef();
		if (gentle_coefs)
			return SMP_W'(int'($urandom_range(0, 2047)) - 1024);
		return SMP_W'($urandom);
	endfunction

	// mostly full range, with extremes and tiny values mixed in
	function automatic logic signed [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0:       return 16'sh7FFF;
					1:       return 16'sh8000;
					2:       return -16'sd1;
					default: return 16'sd0;
				endcase
			end
			1:       return SMP_W'(int'($urandom_range(0, 8)) - 4);
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// Drive one request, hold it until accepted, then apply sender pacing:
	// bursts of random length with random gaps (sometimes none).
	task automatic send_request(logic c, logic ch, logic [TAPI_W-1:0] tap,
			logic signed [SMP_W-1:0] cf, logic signed [SMP_W-1:0] smp);
		int gap;
		in_valid   <= 1'b1;
		cmd        <= c;
		channel    <= ch;
		tap_index  <= tap;
		coef_value <= cf;
		sample_in  <= smp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(c, ch, tap, cf, smp);
		if (c == CMD_FILTER) begin
			n_filter++;
		end else if (tap < CHAN_TAPS) begin
			n_load++;
			coef_loaded[ch][tap] = 1'b1;
		end else begin
			n_stray++;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// unused fields carry random junk
	task automatic load_coef(logic ch, logic [TAPI_W-1:0] tap, logic signed [SMP_W-1:0] cf);
		send_request(CMD_LOAD, ch, tap, cf, SMP_W'($urandom));
	endtask

	// any tap in the active window that was never loaded gets loaded first
	task automatic filter_sample(logic ch, logic signed [SMP_W-1:0] smp);
		for (int k = 0; k < sb.active_taps(); k++)
			if (!coef_loaded[ch][k])
				load_coef(ch, TAPI_W'(k), rand_coef());
		send_request(CMD_FILTER, ch, TAPI_W'($urandom), SMP_W'($urandom), smp);
	endtask

	// stop sending and wait for every due output, then a settle time
	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// half_order only changes while the block is idle
	task automatic write_half_order(logic [HO_W-1:0] v);
		drain_outputs();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_half_order(v);
		n_settings++;
	endtask

	initial begin
		logic [HO_W-1:0] ho;
		int              n;
		int              r;
		int              phase;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed, half_order at its reset value (3 taps) ----
		load_coef(1'b0, 0, 16'sh7FFF);  // largest positive
		load_coef(1'b0, 1, 16'sh8000);  // most negative
		load_coef(1'b0, 2, 16'sh4000);
		load_coef(1'b1, 0, 16'sh4000);  // 0.5: exposes rounding ties
		load_coef(1'b1, 1, 16'sh0000);
		load_coef(1'b1, 2, 16'sh0000);
		load_coef(1'b0, 128, 16'sd1234); // highest valid tap
		load_coef(1'b1, 129, 16'sh7FFF); // past the store: dropped
		load_coef(1'b0, 255, 16'sh8000); // dropped as well
		// right channel: +-0.5 and +-1.5 round away from zero; history starts at zero
		filter_sample(1'b1, 16'sd1);
		filter_sample(1'b1, -16'sd1);
		filter_sample(1'b1, 16'sd3);
		filter_sample(1'b1, -16'sd3);
		filter_sample(1'b1, 16'sd0);
		// left channel: full-scale samples drive the negative saturation limit
		filter_sample(1'b0, 16'sh7FFF);
		filter_sample(1'b0, 16'sh8000);
		filter_sample(1'b0, 16'sh8000);
		filter_sample(1'b0, 16'sd0);
		// half_order zero behaves as one
		write_half_order(0);
		filter_sample(1'b0, 16'sd1);
		filter_sample(1'b1, 16'sh8000);

		// ---- random phases, each under its own half_order ----
		// opening phases hit the clamp above max, the max itself and the minimum;
		// after that mostly short filters so large orders stay rare
		phase = 0;
		while (n_filter + n_load < ITEM_TARGET) begin
			case (phase)
				0: ho = 7'd127;
				1: ho = HO_W'(MAX_HALF_ORDER);
				2: ho = 7'd1;
				default: begin
					r = $urandom_range(0, 19);
					if (r < 14)
						ho = HO_W'($urandom_range(1, 8));
					else if (r < 18)
						ho = HO_W'($urandom_range(9, 32));
					else
						ho = HO_W'($urandom_range(33, 127));
				end
			endcase
			phase++;
			write_half_order(ho);
			gentle_coefs = 1'($urandom_range(0, 1));
			// short filters get a fresh coefficient set in this phase's style
			if (sb.active_taps() <= 17)
				for (int c = 0; c < NUM_CHANNELS; c++)
					for (int k = 0; k < sb.active_taps(); k++)
						load_coef(1'(c), TAPI_W'(k), rand_coef());
			n = (sb.active_taps() > 33) ? $urandom_range(16, 32) : $urandom_range(50, 140);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 74)
					filter_sample(1'($urandom_range(0, 1)), rand_sample());
				else if (r < 94)
					load_coef(1'($urandom_range(0, 1)),
						TAPI_W'($urandom_range(0, CHAN_TAPS - 1)), rand_coef());
				else if (r < 97)
					load_coef(1'($urandom_range(0, 1)),
						TAPI_W'($urandom_range(CHAN_TAPS, 255)), SMP_W'($urandom));
				else
					drain_outputs(); // hold off until the pipe is empty
			end
		end

		// ---- wind down ----
		drain_outputs();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d filter requests, %0d coefficient loads, %0d dropped loads",
			n_filter, n_load, n_stray);
		$display("over %0d half_order settings; %0d outputs checked, %0d errors",
			n_settings + 1, sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** stereo_fir_filter: PASSED **");
		else
			$display("** stereo_fir_filter: FAILED **");
		$finish;
	end

endmodule
